### src/lzw_pkg.sv
// Shared types and constants for the LZW encoder.
package lzw_pkg;

  localparam int DICT_SIZE_DEF = 4096;
  localparam int BASE_SIZE_DEF = 128;
  localparam int SYM_W = 7;
  localparam int CODE_W = 12;
  localparam int EPOCH_W = 8;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             final_symbol;
  } sym_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              end_of_stream;
  } code_beat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT_RD,
    S_ENTRY_RD,
    S_CMP,
    S_MISS,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_wr;
    logic next_probe;
    logic take_hit;
    logic insert;
    logic emit;
    logic eos;
  } cmd_t;

  typedef struct packed {
    logic prefix_valid;
    logic last;
    logic occupied;
    logic match;
    logic clear_done;
    logic out_free;
    logic epoch_wrap;
  } sts_t;

endpackage

### src/lzw_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface lzw_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### src/lzw_ctrl.sv
// Sequencing state machine for the LZW encoder.
module lzw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lzw_pkg::sts_t sts,
  output lzw_pkg::cmd_t cmd
);
  import lzw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = sts.prefix_valid ? S_SLOT_RD : S_FINISH;
      end
      S_SLOT_RD: state_next = S_ENTRY_RD;
      S_ENTRY_RD: state_next = sts.occupied ? S_CMP : S_MISS;
      S_CMP: state_next = sts.match ? S_FINISH : S_SLOT_RD;
      S_MISS: begin
        if (sts.out_free) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.last) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          state_next = sts.epoch_wrap ? S_CLEAR : S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: cmd.clear_wr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CMP: begin
        cmd.take_hit   = sts.match;
        cmd.next_probe = !sts.match;
      end
      S_MISS: begin
        cmd.emit   = sts.out_free;
        cmd.insert = sts.out_free;
      end
      S_FINISH: begin
        cmd.emit = sts.last && sts.out_free;
        cmd.eos  = sts.last && sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### src/lzw_dpath.sv
// Datapath: prefix state, hashed code index, dictionary memories, output register.
module lzw_dpath #(
  parameter int DICT_SIZE = lzw_pkg::DICT_SIZE_DEF,
  parameter int BASE_SIZE = lzw_pkg::BASE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lzw_pkg::cmd_t       cmd,
  output lzw_pkg::sts_t       sts,
  input  lzw_pkg::sym_beat_t  in_data,
  input  logic                out_ready,
  output logic                out_valid,
  output lzw_pkg::code_beat_t out_data
);
  import lzw_pkg::*;

  localparam int CW = $clog2(DICT_SIZE);
  localparam int HW = CW + 1;
  localparam int SLOTS = 2 ** HW;

  logic [EPOCH_W+CW-1:0] slot_mem [SLOTS];
  logic [CW-1:0] ent_prefix_mem [DICT_SIZE];
  logic [SYM_W-1:0] ent_sym_mem [DICT_SIZE];

  logic [SYM_W-1:0]      sym_q;
  logic                  last_q;
  logic [CW-1:0]         prefix;
  logic                  prefix_valid;
  logic [CW:0]           next_free;
  logic [EPOCH_W-1:0]    epoch;
  logic [HW-1:0]         probe_idx;
  logic [HW-1:0]         clr_idx;
  logic [EPOCH_W+CW-1:0] slot_q;
  logic [CW-1:0]         ent_prefix_q;
  logic [SYM_W-1:0]      ent_sym_q;

  logic [SYM_W-1:0]   sym_c;
  logic [HW-1:0]      hash_c;
  logic               room;
  logic [CW-1:0]      slot_code;
  logic [EPOCH_W-1:0] slot_tag;

  always_comb begin
    if (9'(in_data.symbol) >= 9'(BASE_SIZE)) begin
      sym_c = SYM_W'(BASE_SIZE - 1);
    end else begin
      sym_c = in_data.symbol;
    end
    hash_c = HW'(prefix) ^ (HW'(sym_c) << (HW - SYM_W));
    room   = next_free < (CW+1)'(DICT_SIZE);
  end

  assign slot_code = slot_q[CW-1:0];
  assign slot_tag  = slot_q[EPOCH_W+CW-1:CW];

  assign sts.prefix_valid = prefix_valid;
  assign sts.last         = last_q;
  assign sts.occupied     = (slot_tag == epoch) &&
                            ((CW+1)'(slot_code) >= (CW+1)'(BASE_SIZE)) &&
                            ((CW+1)'(slot_code) < next_free);
  assign sts.match        = (ent_prefix_q == prefix) && (ent_sym_q == sym_q);
  assign sts.clear_done   = &clr_idx;
  assign sts.out_free     = !out_valid || out_ready;
  assign sts.epoch_wrap   = &epoch;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix       <= '0;
      prefix_valid <= 1'b0;
      next_free    <= (CW+1)'(BASE_SIZE);
      epoch        <= '0;
      clr_idx      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_idx <= clr_idx + 1'b1;
      if (cmd.load) begin
        sym_q     <= sym_c;
        last_q    <= in_data.final_symbol;
        probe_idx <= hash_c;
        if (!prefix_valid) begin
          prefix       <= CW'(sym_c);
          prefix_valid <= 1'b1;
        end
      end
      if (cmd.next_probe) probe_idx <= probe_idx + 1'b1;
      if (cmd.take_hit) prefix <= slot_code;
      if (cmd.insert) begin
        prefix <= CW'(sym_q);
        if (room) next_free <= next_free + 1'b1;
      end
      if (cmd.emit) begin
        out_valid              <= 1'b1;
        out_data.code          <= CODE_W'(prefix);
        out_data.end_of_stream <= cmd.eos;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.eos) begin
        next_free    <= (CW+1)'(BASE_SIZE);
        prefix       <= '0;
        prefix_valid <= 1'b0;
        epoch        <= epoch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      slot_mem[clr_idx] <= '0;
    end else if (cmd.insert && room) begin
      slot_mem[probe_idx] <= {epoch, next_free[CW-1:0]};
    end
    slot_q <= slot_mem[probe_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && room) begin
      ent_prefix_mem[next_free[CW-1:0]] <= prefix;
      ent_sym_mem[next_free[CW-1:0]]    <= sym_q;
    end
    ent_prefix_q <= ent_prefix_mem[slot_code];
    ent_sym_q    <= ent_sym_mem[slot_code];
  end

  a_eos_resets: assert property (@(posedge clk) disable iff (rst)
    cmd.eos |=> (next_free == (CW+1)'(BASE_SIZE)) && !prefix_valid)
    else $error("dictionary not reset after end of stream");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.take_hit |-> sts.occupied && sts.match)
    else $error("hit taken from an empty or mismatching slot");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || out_ready)
    else $error("result overwrites an undelivered beat");

  a_start_prefix: assert property (@(posedge clk) disable iff (rst)
    cmd.load && !prefix_valid && !in_data.final_symbol |=> prefix_valid)
    else $error("prefix not started on first symbol");

endmodule

### src/lzw_encoder.sv
// Top level of the LZW encoder: controller, datapath and stream ports.
// Steps: a stream's first symbol goes from idle to finish; others pass slot read, entry
// read, compare or miss, then finish, redoing the reads and compare per extra hash probe;
// codes leave from an output register. Symbols are taken singly, when idle; a full output
// register stalls emits. Reset: synchronous; the code index, 2 * 2**clog2(DICT_SIZE) slots
// (8192 by default), is wiped before the first beat and after every 2**EPOCH_W streams.
module lzw_encoder #(
  parameter int DICT_SIZE = lzw_pkg::DICT_SIZE_DEF,
  parameter int BASE_SIZE = lzw_pkg::BASE_SIZE_DEF
) (
  input logic          clk,
  input logic          rst,
  lzw_stream_if.sink   in_stream,
  lzw_stream_if.source out_stream
);
  import lzw_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic       in_ready;
  logic       out_valid;
  code_beat_t out_data;
  sym_beat_t  in_data;

  assign in_data          = in_stream.data;
  assign in_stream.ready  = in_ready;
  assign out_stream.valid = out_valid;
  assign out_stream.data  = out_data;

  lzw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_stream.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzw_dpath #(
    .DICT_SIZE (DICT_SIZE),
    .BASE_SIZE (BASE_SIZE)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_ready (out_stream.ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
